// File: src/uttx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uttx_pkg
// Shared types and constants of the UUID text timestamp extractor.
// ----------------------------------------------------------------------------
package uttx_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned TEXT_LEN   = 36;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned ODD_W      = 17;
  localparam int unsigned MAGIC_W    = 26;
  localparam int unsigned PART_W     = ODD_W + 8;
  localparam int unsigned PROD_W     = PART_W + MAGIC_W;

  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_F  = 8'h66;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_F  = 8'h46;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_MALFORMED = 2'd1;
  localparam logic [1:0] STATUS_NO_TIME   = 2'd2;

  localparam logic [3:0] VER_GREGORIAN = 4'd1;
  localparam logic [3:0] VER_UNIX_MS   = 4'd7;

  localparam logic [TIME_W-1:0] GREGORIAN_OFFSET = 64'd122192928000000000;

  localparam logic [1:0] DIV_NONE    = 2'd0;
  localparam logic [1:0] DIV_MS_S    = 2'd1;
  localparam logic [1:0] DIV_TICK_MS = 2'd2;
  localparam logic [1:0] DIV_TICK_S  = 2'd3;

  typedef struct packed {
    logic [1:0]        status;
    logic [3:0]        version;
    logic [TIME_W-1:0] value;
    logic [1:0]        div_sel;
  } job_t;

  // Each divisor is split into a power of two, removed by a shift, and an
  // odd part, which is divided a byte at a time by multiplying with its
  // rounded-up reciprocal. The reciprocal is exact for partial dividends
  // below 2^25.
  function automatic logic [2:0] pow2_of(input logic [1:0] sel);
    logic [2:0] s;
    case (sel)
      DIV_MS_S:    s = 3'd3;
      DIV_TICK_MS: s = 3'd4;
      DIV_TICK_S:  s = 3'd7;
      default:     s = 3'd0;
    endcase
    return s;
  endfunction

  function automatic logic [ODD_W-1:0] odd_of(input logic [1:0] sel);
    logic [ODD_W-1:0] d;
    case (sel)
      DIV_MS_S:    d = 17'd125;
      DIV_TICK_MS: d = 17'd625;
      DIV_TICK_S:  d = 17'd78125;
      default:     d = 17'd1;
    endcase
    return d;
  endfunction

  function automatic logic [MAGIC_W-1:0] magic_of(input logic [1:0] sel);
    logic [MAGIC_W-1:0] m;
    case (sel)
      DIV_MS_S:    m = 26'd34359739;
      DIV_TICK_MS: m = 26'd54975582;
      DIV_TICK_S:  m = 26'd56294996;
      default:     m = 26'd0;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] magic_shift_of(input logic [1:0] sel);
    logic [5:0] s;
    case (sel)
      DIV_MS_S:    s = 6'd32;
      DIV_TICK_MS: s = 6'd35;
      DIV_TICK_S:  s = 6'd42;
      default:     s = 6'd0;
    endcase
    return s;
  endfunction

endpackage

// File: src/uttx_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uttx_front
// Parses the UUID text one character per item and emits one job per text.
// ----------------------------------------------------------------------------
module uttx_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          item_valid_i,
  input  logic [7:0]    char_code_i,
  input  logic          last_char_i,
  output logic          job_valid_o,
  output uttx_pkg::job_t job_o
);
  import uttx_pkg::*;

  logic              seconds_q;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              err_q, err_d;
  logic [3:0]        ver_q, ver_d;
  logic [31:0]       low_q, low_d;
  logic [15:0]       mid_q, mid_d;
  logic [11:0]       high_q, high_d;

  logic       is_digit, is_lc, is_uc, is_hex, dash_pos, beyond, bad, err_all;
  logic [3:0] nib;
  logic [7:0] lc_off, uc_off;

  assign is_digit = (char_code_i >= CHAR_0) && (char_code_i <= CHAR_9);
  assign is_lc    = (char_code_i >= CHAR_LC_A) && (char_code_i <= CHAR_LC_F);
  assign is_uc    = (char_code_i >= CHAR_UC_A) && (char_code_i <= CHAR_UC_F);
  assign is_hex   = is_digit || is_lc || is_uc;
  assign lc_off   = char_code_i - CHAR_LC_A + 8'd10;
  assign uc_off   = char_code_i - CHAR_UC_A + 8'd10;

  always_comb begin
    nib = 4'd0;
    if (is_digit) begin
      nib = char_code_i[3:0];
    end else if (is_lc) begin
      nib = lc_off[3:0];
    end else if (is_uc) begin
      nib = uc_off[3:0];
    end
  end

  assign beyond   = pos_q >= POS_W'(TEXT_LEN);
  assign dash_pos = (pos_q == 6'd8) || (pos_q == 6'd13) || (pos_q == 6'd18) ||
                    (pos_q == 6'd23);

  always_comb begin
    if (beyond) begin
      bad = 1'b1;
    end else if (dash_pos) begin
      bad = char_code_i != CHAR_DASH;
    end else begin
      bad = !is_hex;
    end
  end

  always_comb begin
    pos_d  = pos_q;
    err_d  = err_q;
    ver_d  = ver_q;
    low_d  = low_q;
    mid_d  = mid_q;
    high_d = high_q;
    if (item_valid_i) begin
      if (last_char_i) begin
        pos_d  = '0;
        err_d  = 1'b0;
        ver_d  = '0;
        low_d  = '0;
        mid_d  = '0;
        high_d = '0;
      end else begin
        err_d = err_q | bad;
        if (pos_q != '1) begin
          pos_d = pos_q + 1'b1;
        end
        if (!beyond && !dash_pos) begin
          if (pos_q < 6'd8) begin
            low_d = {low_q[27:0], nib};
          end else if (pos_q < 6'd13) begin
            mid_d = {mid_q[11:0], nib};
          end else if (pos_q == 6'd14) begin
            ver_d = nib;
          end else if (pos_q < 6'd18) begin
            high_d = {high_q[7:0], nib};
          end
        end
      end
    end
  end

  assign err_all = err_q | bad;

  always_comb begin
    job_o.status  = STATUS_NO_TIME;
    job_o.version = ver_q;
    job_o.value   = '0;
    job_o.div_sel = DIV_NONE;
    if (err_all || (pos_q != POS_W'(TEXT_LEN - 1))) begin
      job_o.status  = STATUS_MALFORMED;
      job_o.version = '0;
    end else if (ver_q == VER_GREGORIAN) begin
      job_o.status  = STATUS_OK;
      job_o.value   = {4'd0, high_q, mid_q, low_q};
      job_o.div_sel = seconds_q ? DIV_TICK_S : DIV_TICK_MS;
    end else if (ver_q == VER_UNIX_MS) begin
      job_o.status  = STATUS_OK;
      job_o.value   = {16'd0, low_q, mid_q};
      job_o.div_sel = seconds_q ? DIV_MS_S : DIV_NONE;
    end
  end

  assign job_valid_o = item_valid_i && last_char_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seconds_q <= 1'b0;
      pos_q     <= '0;
      err_q     <= 1'b0;
      ver_q     <= '0;
      low_q     <= '0;
      mid_q     <= '0;
      high_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        seconds_q <= cfg_wdata_i;
      end
      pos_q  <= pos_d;
      err_q  <= err_d;
      ver_q  <= ver_d;
      low_q  <= low_d;
      mid_q  <= mid_d;
      high_q <= high_d;
    end
  end

endmodule

// File: src/uttx_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uttx_fifo
// Short register queue of jobs between the parser and the divider.
// ----------------------------------------------------------------------------
module uttx_fifo #(
  parameter int unsigned Depth = uttx_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  uttx_pkg::job_t wdata_i,
  output logic           full_o,
  input  logic           rd_i,
  output logic           empty_o,
  output uttx_pkg::job_t rdata_o
);
  import uttx_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= next_ptr(wptr_q);
      end
      if (do_rd) begin
        rptr_q <= next_ptr(rptr_q);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: src/uttx_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uttx_back
// Applies the epoch offset for version 1, divides by a constant a byte at a
// time unless no division is selected, and holds the result for the consumer.
// ----------------------------------------------------------------------------
module uttx_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_empty_i,
  input  uttx_pkg::job_t              job_i,
  output logic                        job_pop_o,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [1:0]                  status_o,
  output logic [3:0]                  version_o,
  output logic [uttx_pkg::TIME_W-1:0] unix_time_o
);
  import uttx_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_SUB  = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [2:0]        step_q;
  logic [TIME_W-1:0] num_q;
  logic [ODD_W-1:0]  rem_q;
  logic [7:0]        qd_q;
  logic [1:0]        sel_q;
  logic [1:0]        stat_q;
  logic [3:0]        ver_q;

  logic              res_valid_q;
  logic [1:0]        res_stat_q;
  logic [3:0]        res_ver_q;
  logic [TIME_W-1:0] res_time_q;

  logic              out_free, load, emit;
  logic [TIME_W-1:0] start_val, shifted;
  logic [PART_W-1:0] partial, qm, rem_full;
  logic [PROD_W-1:0] prod;
  logic [7:0]        qd_d;

  assign out_free  = !res_valid_q || pop_i;
  assign emit      = (state_q == ST_HOLD) && out_free;
  assign load      = !job_empty_i && ((state_q == ST_IDLE) || emit);
  assign job_pop_o = load;

  always_comb begin
    start_val = job_i.value;
    if ((job_i.div_sel == DIV_TICK_MS) || (job_i.div_sel == DIV_TICK_S)) begin
      start_val = job_i.value - GREGORIAN_OFFSET;
    end
  end

  assign shifted = start_val >> pow2_of(job_i.div_sel);

  assign partial  = {rem_q, num_q[TIME_W-1 -: 8]};
  assign prod     = PROD_W'(partial) * PROD_W'(magic_of(sel_q));
  assign qd_d     = 8'(prod >> magic_shift_of(sel_q));
  assign qm       = PART_W'(qd_q) * PART_W'(odd_of(sel_q));
  assign rem_full = partial - qm;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (load) begin
          state_d = (job_i.div_sel == DIV_NONE) ? ST_HOLD : ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_SUB;
      end
      ST_SUB: begin
        state_d = (step_q == '1) ? ST_HOLD : ST_MUL;
      end
      ST_HOLD: begin
        if (load) begin
          state_d = (job_i.div_sel == DIV_NONE) ? ST_HOLD : ST_MUL;
        end else if (emit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      num_q  <= shifted;
      rem_q  <= '0;
      sel_q  <= job_i.div_sel;
      stat_q <= job_i.status;
      ver_q  <= job_i.version;
    end else if (state_q == ST_MUL) begin
      qd_q <= qd_d;
    end else if (state_q == ST_SUB) begin
      num_q <= {num_q[TIME_W-9:0], qd_q};
      rem_q <= rem_full[ODD_W-1:0];
    end
    if (emit) begin
      res_stat_q <= stat_q;
      res_ver_q  <= ver_q;
      res_time_q <= num_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        step_q <= '0;
      end else if (state_q == ST_SUB) begin
        step_q <= step_q + 1'b1;
      end
      if (emit) begin
        res_valid_q <= 1'b1;
      end else if (pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign empty_o     = !res_valid_q;
  assign status_o    = res_stat_q;
  assign version_o   = res_ver_q;
  assign unix_time_o = res_time_q;

endmodule

// File: src/uuid_text_timestamp_extractor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uuid_text_timestamp_extractor_unit
// Extracts the Unix time from a UUID in text form, one character per item.
// ----------------------------------------------------------------------------
// The text enters at one character per clock with no gaps required while
// the queue is not full, and each final character places one job in a
// queue of QueueDepth entries. A result with status ok for version 1, or for
// version 7 in seconds mode, passes through a constant divider that handles
// the dividend one byte at a time, with a multiply step and a subtract step
// per byte, before it is held and registered on the result side; every other
// result passes from its hold state straight into the result registers, and
// such results follow one another every cycle while they are being taken. A
// divided result frees the divider before a full text can arrive, so input
// stalls only when the queue is full because results are not being taken.
module uuid_text_timestamp_extractor_unit #(
  parameter int unsigned QueueDepth = uttx_pkg::QUEUE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  char_code_i,
  input  logic                        last_char_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [1:0]                  status_o,
  output logic [3:0]                  version_o,
  output logic [uttx_pkg::TIME_W-1:0] unix_time_o
);
  import uttx_pkg::*;

  logic accept, job_valid, job_empty, job_pop;
  job_t job_in, job_out;

  assign accept = push && !full;

  uttx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_valid_i(accept),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .job_valid_o (job_valid),
    .job_o       (job_in)
  );

  uttx_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (job_valid),
    .wdata_i(job_in),
    .full_o (full),
    .rd_i   (job_pop),
    .empty_o(job_empty),
    .rdata_o(job_out)
  );

  uttx_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_empty_i(job_empty),
    .job_i      (job_out),
    .job_pop_o  (job_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .status_o   (status_o),
    .version_o  (version_o),
    .unix_time_o(unix_time_o)
  );

endmodule
